/* hw/rtl/sed_pkg.sv */
// Shared types and constants for the RGB Sobel edge unit.
package sed_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GRAD_W     = 11;  // |g| <= 1020, signed
  localparam int unsigned SUMSQ_W    = 21;  // 2 * 1020^2 < 2^21
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam logic [SUMSQ_W-1:0] SAT_SUMSQ = 21'd65280;
  localparam logic [PIX_W-1:0]   SAT_LIMIT = 8'd255;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } out_word_t;

  typedef logic [3*PIX_W-1:0] rgb_t;

endpackage

/* hw/rtl/sed_ram.sv */
// Generic simple dual-port RAM with registered read.
module sed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sobel_edge_rgb_unit.sv */
// Top level of the streaming 3x3 Sobel edge unit for RGB pixels.
//
// Input channel in_*: one word per pixel in raster order; command = flush
// sends a zero pixel used to drain the last frame_width+1 results.
// Output channel out_*: Sobel magnitude per color, saturated at 255, with
// last_pixel on the frame's final result. Result for pixel p is produced by
// the input word with raster index p + frame_width + 1.
// Config channel cfg_*: index 0 = frame_width, 1 = frame_height. A write to
// either restarts the frame; it is taken only while the unit is idle, and a
// pending write holds off the input channel.
// Sequence: a word that yields a result passes from its accept through the
// line-store read, gradient, squares, 8 root steps, rounding and load, then
// the idle state that takes the next word; its result becomes valid once the
// output register is loaded. A word without a result returns to idle from the
// line-store read. The 8-step bitwise square root dominates this sequence.
// The output register decouples the sides: the next word is accepted while a
// result waits; a stalled receiver holds the sequencer in its final state.
// Reset (synchronous, rst_n low) restores 640x480 and restarts the frame.
// The line stores need no clearing: unwritten entries only reach masked taps.
module sobel_edge_rgb_unit
  import sed_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_word_t     in_word,
  output logic         out_valid,
  input  logic         out_stall,
  output out_word_t    out_word,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [FH_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_RND  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [CW-1:0]   w_m1;
  logic [ROW_W-1:0] h_m1;

  // effective width/height, saturated into range
  always_comb begin
    logic [EW-1:0] fw_ext;
    fw_ext = EW'(fw_r);
    if (fw_r == '0) w_m1 = '0;
    else if (fw_ext > EW'(MAX_WIDTH)) w_m1 = CW'(MAX_WIDTH - 1);
    else w_m1 = CW'(fw_ext - EW'(1));
    if (fh_r == '0) h_m1 = '0;
    else if (fh_r > FH_W'(MAX_HEIGHT)) h_m1 = ROW_W'(MAX_HEIGHT - 1);
    else h_m1 = ROW_W'(fh_r - FH_W'(1));
  end

  // input position
  logic [CW-1:0]    in_col_r;
  logic [1:0]       in_row_r;
  // output position
  logic [CW-1:0]    out_col_r;
  logic [ROW_W-1:0] out_row_r;

  // latched item
  logic [CW-1:0] c_r;
  rgb_t          pix_r;
  logic          emit_r;

  rgb_t win_r [3][3];

  // line stores: {upper, middle} per column
  logic [6*PIX_W-1:0] ram_rd;
  logic               ram_we;

  sed_ram #(.WIDTH(6*PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (c_r),
    .wr_data ({ram_rd[3*PIX_W-1:0], pix_r}),
    .rd_addr (in_col_r),
    .rd_data (ram_rd)
  );

  logic in_acc, cfg_acc, out_load, last_w;
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign ram_we    = (state_r == S_RD);
  assign out_load  = (state_r == S_OUT) && (!out_valid || !out_stall);
  assign last_w    = (out_row_r == h_m1) && (out_col_r == w_m1);

  // gradient / magnitude datapath, three colors side by side
  logic signed [GRAD_W-1:0] gx_r [3], gy_r [3];
  logic [SUMSQ_W-1:0]       ss_r [3];
  logic [PIX_W-1:0]         n_r [3], res_r [3];
  logic [2:0]               step_r;
  logic signed [GRAD_W-1:0] gx_nxt [3], gy_nxt [3];

  always_comb begin
    logic signed [GRAD_W-1:0] a [3][3];
    logic mr0, mr2, mk0, mk2;
    mr0 = (out_row_r == '0);
    mr2 = (out_row_r == h_m1);
    mk0 = (out_col_r == '0);
    mk2 = (out_col_r == w_m1);
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          a[r][k] = GRAD_W'(win_r[r][k][(2-ch)*PIX_W +: PIX_W]);
          if ((r == 0 && mr0) || (r == 2 && mr2) || (k == 0 && mk0) || (k == 2 && mk2))
            a[r][k] = '0;
        end
      end
      gx_nxt[ch] = a[0][2] - a[0][0] + ((a[1][2] - a[1][0]) <<< 1) + a[2][2] - a[2][0];
      gy_nxt[ch] = a[2][0] - a[0][0] + ((a[2][1] - a[0][1]) <<< 1) + a[2][2] - a[0][2];
    end
  end

  always_ff @(posedge clk) begin
    logic [PIX_W-1:0]      t;
    logic [2*PIX_W-1:0]    tt;
    logic [2*PIX_W:0]      rem;
    logic signed [SUMSQ_W-1:0] gxe, gye;
    if (state_r == S_IDLE && in_acc) begin
      c_r    <= in_col_r;
      pix_r  <= (in_word.command == CMD_FLUSH) ? '0
              : {in_word.red_in, in_word.green_in, in_word.blue_in};
      emit_r <= (in_row_r == 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);
    end
    for (int ch = 0; ch < 3; ch++) begin
      unique case (state_r)
        S_GRAD: begin
          gx_r[ch] <= gx_nxt[ch];
          gy_r[ch] <= gy_nxt[ch];
        end
        S_SQ: begin
          // full-width operands so the squares do not wrap
          gxe = SUMSQ_W'(gx_r[ch]);
          gye = SUMSQ_W'(gy_r[ch]);
          ss_r[ch] <= SUMSQ_W'(gxe * gxe) + SUMSQ_W'(gye * gye);
          n_r[ch]  <= '0;
        end
        S_ROOT: begin
          t  = n_r[ch] | (8'h80 >> step_r);
          tt = t * t;
          if (SUMSQ_W'(tt) <= ss_r[ch]) n_r[ch] <= t;
        end
        S_RND: begin
          rem = 17'(ss_r[ch]) - (17'(n_r[ch]) * 17'(n_r[ch]));
          if (ss_r[ch] > SAT_SUMSQ) res_r[ch] <= SAT_LIMIT;
          else if (rem > 17'(n_r[ch]) && n_r[ch] != SAT_LIMIT) res_r[ch] <= n_r[ch] + 8'd1;
          else res_r[ch] <= n_r[ch];
        end
        default: ;
      endcase
    end
    if (out_load) begin
      out_word <= '{red_out: res_r[0], green_out: res_r[1], blue_out: res_r[2],
                    last_pixel: last_w};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD:   state_nxt = emit_r ? S_GRAD : S_IDLE;
      S_GRAD: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ROOT;
      S_ROOT: if (step_r == 3'd7) state_nxt = S_RND;
      S_RND:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fw_r      <= FW_W'(640);
      fh_r      <= FH_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_valid <= 1'b0;
      step_r    <= '0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) win_r[r][k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      step_r <= (state_r == S_ROOT) ? step_r + 3'd1 : '0;

      if (cfg_acc) begin
        if (cfg_index == REG_FRAME_WIDTH)  fw_r <= cfg_data[FW_W-1:0];
        if (cfg_index == REG_FRAME_HEIGHT) fh_r <= cfg_data;
        if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++) win_r[r][k] <= '0;
        end
      end

      if (in_acc) begin
        if (in_col_r == w_m1) begin
          in_col_r <= '0;
          if (in_row_r != 2'd2) in_row_r <= in_row_r + 2'd1;
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end

      // shift window; new column comes from line stores and the pixel
      if (state_r == S_RD) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= ram_rd[6*PIX_W-1:3*PIX_W];
        win_r[1][2] <= ram_rd[3*PIX_W-1:0];
        win_r[2][2] <= pix_r;
      end

      if (out_load) begin
        if (last_w) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++) win_r[r][k] <= '0;
        end else if (out_col_r == w_m1) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

endmodule
